/* design/pss_pkg.sv */
// Shared types, constants and character class functions of the printable string scanner.
`timescale 1ns / 1ps

package pss_pkg;

   // Width of the byte position counter; positions wrap modulo 2**OFFSET_BITS.
   localparam int OFFSET_BITS = 32;

   localparam int MIN_LEN_BITS = 16;
   localparam int ENTRY_BITS   = 20;
   localparam int FIELD_BITS   = 32;
   localparam int SLOT_COUNT   = 3;

   // Result kinds.
   localparam logic [1:0] KIND_ASCII = 2'd0;
   localparam logic [1:0] KIND_WIDE  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // Register indexes of the configuration port.
   localparam logic CSR_MIN_LENGTH  = 1'b0;
   localparam logic CSR_MAX_ENTRIES = 1'b1;

   localparam logic [MIN_LEN_BITS-1:0] MIN_LENGTH_RESET  = 16'd4;
   localparam logic [MIN_LEN_BITS-1:0] MIN_LENGTH_FLOOR  = 16'd2;
   localparam logic [ENTRY_BITS-1:0]   MAX_ENTRIES_RESET = 20'd1000000;

   typedef logic [OFFSET_BITS-1:0] pos_type;

   typedef struct packed {
      logic [MIN_LEN_BITS-1:0] min_length;
      logic [ENTRY_BITS-1:0]   max_entries;
   } cfg_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [FIELD_BITS-1:0] start_offset;
      logic [FIELD_BITS-1:0] char_length;
      logic                  limited;
      logic [ENTRY_BITS-1:0] entry_count;
      logic                  last_of_item;
   } result_type;

   // Printable ASCII byte.
   function automatic logic is_text_byte(input logic [7:0] b);
      return (b >= 8'h20) && (b <= 8'h7e);
   endfunction

   // Printable UTF-16 unit, with format and separator controls excluded.
   function automatic logic is_text_unit(input logic [15:0] u);
      logic excl;
      logic incl;
      excl = ((u >= 16'h200b) && (u <= 16'h200f)) || ((u >= 16'h2028) && (u <= 16'h202e)) ||
             ((u >= 16'h2060) && (u <= 16'h206f)) || (u == 16'h00ad) || (u == 16'h061c);
      incl = ((u >= 16'h0020) && (u <= 16'h007e)) || ((u >= 16'h00a0) && (u <= 16'h2fff)) ||
             ((u >= 16'h3040) && (u <= 16'hd7a3)) || ((u >= 16'hf900) && (u <= 16'hfaff)) ||
             ((u >= 16'hff01) && (u <= 16'hffef));
      return incl && !excl;
   endfunction

   // Low 32 bits of a position.
   function automatic logic [FIELD_BITS-1:0] pos_low(input pos_type p);
      logic [63:0] w;
      w = 64'(p);
      return w[FIELD_BITS-1:0];
   endfunction

   // Length shown in 32 bits, saturating.
   function automatic logic [FIELD_BITS-1:0] len_sat(input pos_type len);
      logic [63:0] w;
      w = 64'(len);
      return (w[63:FIELD_BITS] != '0) ? '1 : w[FIELD_BITS-1:0];
   endfunction

endpackage

/* design/pss_scan_core.sv */
// Run tracking state and per-byte result generation of the printable string scanner.
`timescale 1ns / 1ps

module pss_scan_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [7:0]                  data_byte,
   input  logic                        last_byte,
   input  pss_pkg::cfg_type            cfg,
   output pss_pkg::result_type         slot [pss_pkg::SLOT_COUNT],
   output logic [pss_pkg::SLOT_COUNT-1:0] slot_valid
);
   import pss_pkg::*;

   // Scan state.
   pos_type               pos_ff, pos_in;
   logic [7:0]            prev_ff, prev_in;
   logic                  pv_ff, pv_in;
   logic                  aa_ff, aa_in;
   pos_type               as_ff, as_in;
   logic [1:0]            wa_ff, wa_in;
   pos_type               ws_ff [2];
   pos_type               ws_in [2];
   logic [ENTRY_BITS-1:0] cnt_ff, cnt_in;
   logic                  lim_ff, lim_in;

   logic [MIN_LEN_BITS-1:0] minlen;
   logic                    text_b;
   logic                    a_cand, a_qual, a_full, a_ok;
   pos_type                 a_start, a_len;
   logic [ENTRY_BITS-1:0]   cnt1, cnt2;
   logic                    lim1, lim2;
   pos_type                 wi, w_len;
   logic                    wlane;
   logic [15:0]             unit;
   logic                    text_u, w_cand, w_qual, w_full, w_ok;

   // ASCII run, then the UTF-16 run at the alignment of the unit that ends here.
   always_comb begin
      minlen  = (cfg.min_length < MIN_LENGTH_FLOOR) ? MIN_LENGTH_FLOOR : cfg.min_length;
      text_b  = is_text_byte(data_byte);
      a_cand  = (aa_ff && !text_b) || (last_byte && (aa_ff || text_b));
      a_start = aa_ff ? as_ff : pos_ff;
      a_len   = text_b ? pos_type'(pos_ff + pos_type'(1) - a_start) : pos_type'(pos_ff - as_ff);
      a_qual  = a_cand && (64'(a_len) >= 64'(minlen));
      a_full  = cnt_ff >= cfg.max_entries;
      a_ok    = a_qual && !a_full;
      lim1    = lim_ff || (a_qual && a_full);
      cnt1    = a_ok ? ENTRY_BITS'(cnt_ff + 1'b1) : cnt_ff;

      wi      = pos_type'(pos_ff - pos_type'(1));
      wlane   = wi[0];
      unit    = {data_byte, prev_ff};
      text_u  = is_text_unit(unit);
      w_cand  = pv_ff && !text_u && wa_ff[wlane] && (unit == 16'h0000);
      w_len   = pos_type'(wi - ws_ff[wlane]) >> 1;
      w_qual  = w_cand && (64'(w_len) >= 64'(minlen));
      w_full  = cnt1 >= cfg.max_entries;
      w_ok    = w_qual && !w_full;
      lim2    = lim1 || (w_qual && w_full);
      cnt2    = w_ok ? ENTRY_BITS'(cnt1 + 1'b1) : cnt1;
   end

   // Results in completion order: ASCII, UTF-16, end marker.
   always_comb begin
      slot[0] = '{kind: KIND_ASCII, start_offset: pos_low(a_start), char_length: len_sat(a_len),
                  limited: lim1, entry_count: cnt1, last_of_item: !(w_ok || last_byte)};
      slot[1] = '{kind: KIND_WIDE, start_offset: pos_low(ws_ff[wlane]),
                  char_length: len_sat(w_len), limited: lim2, entry_count: cnt2,
                  last_of_item: !last_byte};
      slot[2] = '{kind: KIND_END, start_offset: pos_low(pos_type'(pos_ff + pos_type'(1))),
                  char_length: '0, limited: lim2, entry_count: cnt2, last_of_item: 1'b1};
      slot_valid = {last_byte, w_ok, a_ok};
   end

   // Next state; the last byte of a buffer returns everything to reset.
   always_comb begin
      pos_in  = pos_type'(pos_ff + pos_type'(1));
      prev_in = data_byte;
      pv_in   = 1'b1;
      aa_in   = text_b;
      as_in   = (text_b && !aa_ff) ? pos_ff : as_ff;
      wa_in   = wa_ff;
      ws_in   = ws_ff;
      cnt_in  = cnt2;
      lim_in  = lim2;
      if (pv_ff) begin
         wa_in[wlane] = text_u;
         if (text_u && !wa_ff[wlane]) begin
            ws_in[wlane] = wi;
         end
      end
      if (last_byte) begin
         pos_in  = '0;
         prev_in = '0;
         pv_in   = 1'b0;
         aa_in   = 1'b0;
         as_in   = '0;
         wa_in   = '0;
         ws_in   = '{default: '0};
         cnt_in  = '0;
         lim_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         prev_ff <= '0;
         pv_ff   <= 1'b0;
         aa_ff   <= 1'b0;
         as_ff   <= '0;
         wa_ff   <= '0;
         ws_ff   <= '{default: '0};
         cnt_ff  <= '0;
         lim_ff  <= 1'b0;
      end else if (step) begin
         pos_ff  <= pos_in;
         prev_ff <= prev_in;
         pv_ff   <= pv_in;
         aa_ff   <= aa_in;
         as_ff   <= as_in;
         wa_ff   <= wa_in;
         ws_ff   <= ws_in;
         cnt_ff  <= cnt_in;
         lim_ff  <= lim_in;
      end
   end

endmodule

/* design/printable_string_scanner.sv */
// Top level of the printable string scanner: input register, scan core, result slots.
`timescale 1ns / 1ps

// Printable string scanner.
// The req_ channel carries one byte of a buffer per word; req_tlast marks the
// final byte. The rsp_ channel carries one found string or the end of buffer
// marker per word, with rsp_tlast on the final word caused by one byte.
// Strings come out in the order they complete, ASCII before UTF-16 for one byte.
// The csr_ port writes min_length (index 0) and max_entries (index 1); the user
// must write them only while the block is idle, which the block does not enforce.
// They keep their values across buffers. An accepted byte passes the input
// register and then the result slot bank. Throughput: one byte per cycle while
// each byte yields at most one word and rsp_tready is high; a byte with more
// words (up to three) holds the input; the single bank drains a word per cycle.
// Reset clears all scan state and restores min_length 4 and max_entries 1000000.
// When the receiver stalls, pending words hold and the input register fills,
// after which req_tready stays low until words are taken.
module printable_string_scanner (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte[7:0]
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,   // start_offset[31:0], char_length[63:32],
                                     // limited[64], entry_count[84:65], zero pad
   output logic [1:0]   rsp_tuser,   // kind
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [19:0]  csr_wdata
);
   import pss_pkg::*;

   cfg_type cfg_ff;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       req_acc, in_advance, bank_free, rsp_acc;

   result_type             new_slot [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]  new_valid;
   result_type             slot_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]  mask_ff, mask_in;
   result_type             cur;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_length  <= MIN_LENGTH_RESET;
         cfg_ff.max_entries <= MAX_ENTRIES_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MIN_LENGTH:  cfg_ff.min_length  <= csr_wdata[MIN_LEN_BITS-1:0];
            CSR_MAX_ENTRIES: cfg_ff.max_entries <= csr_wdata[ENTRY_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Handshake control.
   always_comb begin
      rsp_acc     = rsp_tvalid && rsp_tready;
      bank_free   = (mask_ff == '0) || ($countones(mask_ff) == 1 && rsp_tready);
      in_advance  = in_valid_ff && bank_free;
      req_tready  = !in_valid_ff || in_advance;
      req_acc     = req_tvalid && req_tready;
      in_valid_in = req_acc || (in_valid_ff && !in_advance);
      mask_in     = mask_ff;
      if (in_advance) begin
         mask_in = new_valid;
      end else if (rsp_acc) begin
         mask_in = mask_ff & SLOT_COUNT'(mask_ff - 1'b1);
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   pss_scan_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (in_advance),
      .data_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .cfg        (cfg_ff),
      .slot       (new_slot),
      .slot_valid (new_valid)
   );

   // Result slot bank.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         slot_ff <= new_slot;
      end
   end

   // Lowest pending slot goes out first.
   always_comb begin
      if (mask_ff[0]) begin
         cur = slot_ff[0];
      end else if (mask_ff[1]) begin
         cur = slot_ff[1];
      end else begin
         cur = slot_ff[2];
      end
      rsp_tvalid = mask_ff != '0;
      rsp_tdata  = {3'b000, cur.entry_count, cur.limited, cur.char_length, cur.start_offset};
      rsp_tuser  = cur.kind;
      rsp_tlast  = cur.last_of_item;
   end

   // A single pending word is always the final one of its byte.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      $onehot(mask_ff) |-> rsp_tlast)
      else $error("single pending word lacks last flag");

   // More words of the same byte follow a taken word without last.
   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && !rsp_tlast |=> rsp_tvalid)
      else $error("words of one byte broken up");

   // The end marker closes its byte and carries no length.
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END |-> rsp_tlast && cur.char_length == '0)
      else $error("malformed end marker");

   // A held input byte blocks new bytes.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !bank_free |-> !req_tready)
      else $error("input accepted while held byte waits");

endmodule
